### design/iasort_pkg.sv
// shared constants and types for the integer array sorter
package iasort_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } iasort_state_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctl_t;

    // controller status seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             draining;
    } ctrl_status_t;

endpackage

### design/integer_array_sorter_top.sv
// integer array sorter: insertion cell chain with batch drain
//
//  channel   signals                                   transaction
//  --------  ----------------------------------------  ---------------------------
//  input     start, busy, value, last_in               start && !busy at clk edge
//  result    strobe, sorted_value, last_out, overflow  strobe high for one cycle
//
// each element enters the cell chain and lands in sorted place at once
// a last_in transaction is followed by one result per stored element, one per cycle,
// read from the head cell while the chain shifts toward it; busy is high for that run
// reset clears cell valid bits, element count and overflow flag; results cannot stall
module integer_array_sorter_top
    import iasort_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last_in,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflow
);

    cell_ctl_t                ctl;
    ctrl_status_t             status;
    logic signed [DATA_W-1:0] cell_value [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]  cell_valid;
    logic [MAX_ELEMENTS-1:0]  cell_gt;

    iasort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_in  (last_in),
        .busy     (busy),
        .strobe   (strobe),
        .last_out (last_out),
        .overflow (overflow),
        .ctl      (ctl),
        .status   (status)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] l_value;
            logic                     l_valid;
            logic                     l_gt;
            logic signed [DATA_W-1:0] r_value;
            logic                     r_valid;

            if (gi == 0)
            begin : g_head
                assign l_value = '0;
                assign l_valid = 1'b0;
                assign l_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign l_value = cell_value[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_gt    = cell_gt[gi-1];
            end

            if (gi == MAX_ELEMENTS - 1)
            begin : g_tail
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_body
                assign r_value = cell_value[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            iasort_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .new_value   (value),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .left_gt     (l_gt),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .gt          (cell_gt[gi])
            );
        end
    endgenerate

    assign sorted_value = cell_value[0];

    // occupied cells always form an unbroken run from the head
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid & (cell_valid + MAX_ELEMENTS'(1))) == '0))
        else $error("gap in cell chain");

    // occupied cells match the controller count
    assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(cell_valid) == int'(status.count)))
        else $error("cell occupancy differs from count");

    // every result comes from an occupied head cell
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> cell_valid[0])
        else $error("result from empty head cell");

    // the final result of a batch frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_out) |=> !busy)
        else $error("busy after final result");

endmodule

### design/iasort_cell.sv
// one insertion cell: holds one element and trades it with its neighbors
module iasort_cell
    import iasort_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] left_value,
    input  logic                     left_valid,
    input  logic                     left_gt,
    input  logic signed [DATA_W-1:0] right_value,
    input  logic                     right_valid,
    output logic signed [DATA_W-1:0] value,
    output logic                     valid,
    output logic                     gt
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;

    // an empty cell counts as greater, so a new element no smaller than all stored ones lands in the first free slot
    // equal values stay put, keeping arrival order among copies
    assign gt = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.shift_out)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctl.insert)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (gt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### design/iasort_ctrl.sv
// batch controller: element count, overflow flag and drain sequencing
module iasort_ctrl
    import iasort_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         last_in,
    output logic         busy,
    output logic         strobe,
    output logic         last_out,
    output logic         overflow,
    output cell_ctl_t    ctl,
    output ctrl_status_t status
);

    iasort_state_t    state_reg;
    iasort_state_t    state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             accept;
    logic             full;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (cnt_reg == CNT_W'(MAX_ELEMENTS));

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (last_in)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy            = 1'b0;
        strobe          = 1'b0;
        last_out        = 1'b0;
        ctl.insert      = 1'b0;
        ctl.shift_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.insert = accept && !full;
            end
            ST_DRAIN:
            begin
                busy          = 1'b1;
                strobe        = 1'b1;
                last_out      = (cnt_reg == CNT_W'(1));
                ctl.shift_out = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign overflow        = ovf_reg;
    assign status.count    = cnt_reg;
    assign status.draining = (state_reg == ST_DRAIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
        end
    end

    // a drain never starts or runs with nothing stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (cnt_reg != '0))
        else $error("drain with empty store");

    // the overflow flag and the element count are cleared once a batch has gone out
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_out) |=> (!ovf_reg && (cnt_reg == '0)))
        else $error("batch state not cleared after final result");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for the integer array sorter: directed and random batches checked against a sorting scoreboard
module tb_top;
    import iasort_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int RESET_TICKS = 7;
    localparam int CYCLE_LIMIT = 100000;
    localparam int IDLE_PCT    = 22;
    localparam int ITEM_TARGET = 160;
    localparam int MAX_PRINTS  = 20;

    typedef enum int {
        VAL_ANY,
        VAL_NARROW,
        VAL_EDGE
    } value_mix_t;

    // holds the elements of the open batch and the sorted run still to come out
    class sort_scoreboard;
        typedef struct {
            logic signed [DATA_W-1:0] elem;
            logic                     is_last;
            logic                     ovf;
        } sorted_item_t;

        logic signed [DATA_W-1:0] held[$];
        logic                     dropped;
        sorted_item_t             awaited[$];
        int                       errors;
        int                       checked;
        int                       batches;
        int                       ovf_batches;

        function new();
            dropped     = 1'b0;
            errors      = 0;
            checked     = 0;
            batches     = 0;
            ovf_batches = 0;
        endfunction

        task report(string what);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // an accepted input transaction; a last element closes the batch
        function void note_element(logic signed [DATA_W-1:0] v, logic last);
            logic signed [DATA_W-1:0] key;
            int                       j;
            sorted_item_t             r;
            if (held.size() < MAX_ELEMENTS)
                held.push_back(v);
            else
                dropped = 1'b1;
            if (!last)
                return;
            for (int i = 1; i < held.size(); i++)
            begin
                key = held[i];
                j = i;
                while (j > 0 && held[j-1] > key)
                begin
                    held[j] = held[j-1];
                    j--;
                end
                held[j] = key;
            end
            foreach (held[k])
            begin
                r.elem    = held[k];
                r.is_last = (k == held.size() - 1);
                r.ovf     = dropped;
                awaited.push_back(r);
            end
            batches++;
            if (dropped)
                ovf_batches++;
            held.delete();
            dropped = 1'b0;
        endfunction

        task check_result(logic signed [DATA_W-1:0] got_elem, logic got_last, logic got_ovf);
            sorted_item_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result %0d", got_elem));
                return;
            end
            e = awaited.pop_front();
            checked++;
            if (got_elem !== e.elem)
                report($sformatf("sorted_value %0d, wanted %0d", got_elem, e.elem));
            if (got_last !== e.is_last)
                report($sformatf("last_out %b, wanted %b at %0d", got_last, e.is_last, e.elem));
            if (got_ovf !== e.ovf)
                report($sformatf("overflow %b, wanted %b at %0d", got_ovf, e.ovf, e.elem));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
    logic                     strobe;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    sort_scoreboard sb = new();
    int             cycle_count = 0;
    int             items_sent  = 0;
    bit             no_gaps     = 1'b0;

    integer_array_sorter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_in      (last_in),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.awaited.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // results cannot be held off, so every strobe is a transaction
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(sorted_value, last_out, overflow);
    end

    function automatic logic signed [DATA_W-1:0] pick_value(value_mix_t mix);
        logic signed [DATA_W-1:0] edges[7];
        edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh1,
                  32'sh8000_0001, 32'sh7FFF_FFFE};
        case (mix)
            VAL_NARROW: return $signed($urandom_range(16)) - 8;
            VAL_EDGE:   return ($urandom_range(1) == 0) ? edges[$urandom_range(6)]
                                                        : $signed($urandom());
            default:    return $signed($urandom());
        endcase
    endfunction

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            start   <= 1'b0;
            value   <= $urandom();
            last_in <= $urandom_range(1);
            @(posedge clk);
        end
    endtask

    task automatic push_element(logic signed [DATA_W-1:0] v, logic last);
        // one random draw per cycle keeps the idle share near IDLE_PCT
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
            idle_cycles(1);
        start   <= 1'b1;
        value   <= v;
        last_in <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_element(v, last);
        items_sent++;
    endtask

    task automatic send_batch(int n, value_mix_t mix);
        for (int k = 0; k < n; k++)
            push_element(pick_value(mix), k == n - 1);
    endtask

    initial
    begin
        int batch_idx;
        int n;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        value   <= '0;
        last_in <= 1'b0;
        repeat (RESET_TICKS) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single element, both extremes of the range
        push_element(32'sh8000_0000, 1'b1);
        push_element(32'sh7FFF_FFFF, 1'b1);
        // duplicated extremes mixed with values around zero
        push_element(32'sh7FFF_FFFF, 1'b0);
        push_element(32'sh8000_0000, 1'b0);
        push_element(32'sh0, 1'b0);
        push_element(-32'sh1, 1'b0);
        push_element(32'sh1, 1'b0);
        push_element(32'sh7FFF_FFFF, 1'b0);
        push_element(32'sh8000_0000, 1'b1);
        // strictly descending input
        for (int k = 5; k >= 1; k--)
            push_element(k, k == 1);
        // all equal
        for (int k = 0; k < 5; k++)
            push_element(-32'sh7, k == 4);
        // already in order
        push_element(-32'sh1, 1'b0);
        push_element(32'sh0, 1'b1);

        batch_idx = 0;
        while ((items_sent < ITEM_TARGET) || (batch_idx <= 5))
        begin
            no_gaps = (batch_idx >= 4 && batch_idx <= 7);
            if (batch_idx == 2)
                send_batch(MAX_ELEMENTS, VAL_ANY);
            else if (batch_idx == 5)
                // store fills, then both plain and last elements get dropped
                send_batch(MAX_ELEMENTS + $urandom_range(2, 4), VAL_NARROW);
            else
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
                send_batch(n, value_mix_t'($urandom_range(2)));
            end
            batch_idx++;
        end

        idle_cycles(1);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_ELEMENTS + 8) @(posedge clk);

        $display("run covered %0d batches from %0d elements, %0d of them with dropped elements",
                 sb.batches, items_sent, sb.ovf_batches);
        $display("%0d sorted results checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### integer_array_sorter_top.f
design/iasort_pkg.sv
design/iasort_cell.sv
design/iasort_ctrl.sv
design/integer_array_sorter_top.sv
bench/tb_top.sv
